### sv/lkv_pkg.sv
`default_nettype none
package lkv_pkg;

  localparam int KEY_W  = 16;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_SET = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the request word
    logic commit;  // look up, update the slots and load the result
  } cmd_t;

endpackage
`default_nettype wire

### sv/lkv_ctrl.sv
`default_nettype none
module lkv_ctrl (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire           out_ready,
  output lkv_pkg::cmd_t cmd
);
  import lkv_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd           = '0;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### sv/lkv_dp.sv
`default_nettype none
module lkv_dp #(
  parameter int DEPTH = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire lkv_pkg::cmd_t                cmd,
  input  wire                               cfg_we,
  input  wire        [lkv_pkg::CAP_W-1:0]   cfg_wdata,
  input  wire                               in_req_type,
  input  wire        [lkv_pkg::KEY_W-1:0]   in_key,
  input  wire signed [lkv_pkg::DATA_W-1:0]  in_value,
  output logic                              out_hit,
  output logic signed [lkv_pkg::DATA_W-1:0] out_data
);
  import lkv_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > CAP_W) ? CW : CAP_W;

  // request word
  logic              req_type_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] value_r;

  logic [CAP_W-1:0]  capacity_r;
  logic [CW-1:0]     live_count_r, live_count_nxt;

  // slot 0 is most recent; live slots are 0 .. live_count_r-1
  logic [KEY_W-1:0]  slot_key_r  [DEPTH];
  logic [DATA_W-1:0] slot_data_r [DEPTH];

  logic [DEPTH-1:0]  match;
  logic              present;
  logic [IW-1:0]     pos;
  logic [IW-1:0]     pos_eff;
  logic [DATA_W-1:0] hit_data;
  logic              slots_we;

  logic [WW-1:0]     cap_w, cap_eff, after_rm, kept;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_req_type;
      key_r      <= in_key;
      value_r    <= DATA_W'(in_value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r   <= CAP_RESET;
      live_count_r <= '0;
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        live_count_r <= live_count_nxt;
      end
    end
  end

  // parallel compare; keys are unique among live slots, so OR the indices
  always_comb begin
    pos      = '0;
    hit_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (CW'(i) < live_count_r) && (slot_key_r[i] == key_r);
      if (match[i]) begin
        pos      = pos | IW'(i);
        hit_data = hit_data | slot_data_r[i];
      end
    end
    present = |match;
    // a hit rotates up to its slot; a new key shifts the whole row
    pos_eff = present ? pos : IW'(DEPTH - 1);
  end

  always_comb begin
    cap_w    = WW'(capacity_r);
    if (cap_w == '0) begin
      cap_eff = WW'(1);
    end else if (cap_w > WW'(DEPTH)) begin
      cap_eff = WW'(DEPTH);
    end else begin
      cap_eff = cap_w;
    end
    after_rm = WW'(live_count_r) - WW'(present);
    kept     = (after_rm < cap_eff - WW'(1)) ? after_rm : cap_eff - WW'(1);
    if (req_type_r == REQ_SET) begin
      live_count_nxt = CW'(kept + WW'(1));
    end else begin
      live_count_nxt = live_count_r;
    end
    slots_we = cmd.commit && ((req_type_r == REQ_SET) || present);
  end

  always_ff @(posedge clk) begin
    if (slots_we) begin
      slot_key_r[0]  <= key_r;
      slot_data_r[0] <= (req_type_r == REQ_SET) ? value_r : hit_data;
      for (int i = 1; i < DEPTH; i++) begin
        if (IW'(i) <= pos_eff) begin
          slot_key_r[i]  <= slot_key_r[i-1];
          slot_data_r[i] <= slot_data_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit  <= present;
      out_data <= ((req_type_r == REQ_GET) && present) ? $signed(hit_data) : '0;
    end
  end

endmodule
`default_nettype wire

### sv/lru_key_value_cache.sv
// Channel   Handshake              Word
// in        in_valid / in_ready    in_req_type, in_key, in_value
// out       out_valid / out_ready  out_hit, out_data
// cfg       cfg_we (no wait)       cfg_wdata (capacity)
//
// Each request is first captured into the request register, then its key is
// compared against all live slots and the slot row rotated in a single step.
// A new request is taken while the previous result waits in the out register;
// its commit waits until that register is free.
// rst_n is synchronous: the cache comes up empty with capacity 16.
`default_nettype none
module lru_key_value_cache #(
  parameter int DEPTH = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               in_req_type,
  input  wire        [lkv_pkg::KEY_W-1:0]   in_key,
  input  wire signed [lkv_pkg::DATA_W-1:0]  in_value,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              out_hit,
  output logic signed [lkv_pkg::DATA_W-1:0] out_data,
  input  wire                               cfg_we,
  input  wire        [lkv_pkg::CAP_W-1:0]   cfg_wdata
);
  import lkv_pkg::*;

  cmd_t cmd;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lkv_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_req_type (in_req_type),
    .in_key      (in_key),
    .in_value    (in_value),
    .out_hit     (out_hit),
    .out_data    (out_data)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a request is in flight");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_valid && in_ready))
    else $error("committed result not presented");

  a_load_commit_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.commit))
    else $error("load and commit in the same cycle");
`endif

endmodule
`default_nettype wire

### sim/tb_lru_key_value_cache.sv
`default_nettype none
module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_pkg::*;

  localparam int DEPTH       = 16;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASE_WORDS = 128;

  typedef struct packed {
    logic              req;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] data;
  } reply_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PERIODIC
  } rx_pattern_t;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic                     in_req_type = REQ_GET;
  logic [KEY_W-1:0]         in_key      = '0;
  logic signed [DATA_W-1:0] in_value    = '0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic                     out_hit;
  logic signed [DATA_W-1:0] out_data;
  logic                     cfg_we      = 1'b0;
  logic [CAP_W-1:0]         cfg_wdata   = CAP_RESET;

  // cache image kept in recency order, entry 0 most recent
  logic [KEY_W-1:0]  line_key  [DEPTH];
  logic [DATA_W-1:0] line_data [DEPTH];
  int                live_lines   = 0;
  logic [CAP_W-1:0]  capacity_reg = CAP_RESET;

  request_t request_q [$];
  reply_t   reply_q [$];

  int errors        = 0;
  int gets_sent     = 0;
  int sets_sent     = 0;
  int hits_expected = 0;
  int evictions     = 0;
  int cap_writes    = 0;
  int replies_seen  = 0;
  int long_holds    = 0;
  int hold_left     = 0;
  int mode_left     = 0;
  int burst_left    = 1;
  int gap_left      = 0;
  int quiet_cycles  = 0;
  rx_pattern_t rx_mode = RX_FREE;

  lru_key_value_cache #(
    .DEPTH(DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req_type(in_req_type),
    .in_key     (in_key),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit    (out_hit),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Apply one request to the cache image and return the reply it produces.
  function automatic reply_t apply_request(request_t r);
    reply_t           rep;
    int               pos;
    int               cap;
    int               i;
    logic [KEY_W-1:0]  k;
    logic [DATA_W-1:0] d;
    rep = '0;
    pos = -1;
    for (i = 0; i < live_lines; i++) begin
      if (pos < 0 && line_key[i] == r.key) pos = i;
    end
    rep.hit = (pos >= 0);
    if (rep.hit) hits_expected++;
    if (r.req == REQ_GET) begin
      gets_sent++;
      if (pos >= 0) begin
        rep.data = line_data[pos];
        k = line_key[pos];
        d = line_data[pos];
        for (i = pos; i > 0; i--) begin
          line_key[i]  = line_key[i-1];
          line_data[i] = line_data[i-1];
        end
        line_key[0]  = k;
        line_data[0] = d;
      end
    end else begin
      sets_sent++;
      // a set of a present key drops the old entry before any trimming
      if (pos >= 0) begin
        for (i = pos; i < live_lines - 1; i++) begin
          line_key[i]  = line_key[i+1];
          line_data[i] = line_data[i+1];
        end
        live_lines--;
      end
      cap = capacity_reg;
      if (cap < 1) cap = 1;
      if (cap > DEPTH) cap = DEPTH;
      while (live_lines >= cap && live_lines > 0) begin
        live_lines--;
        evictions++;
      end
      if (live_lines >= DEPTH) live_lines = DEPTH - 1;
      for (i = live_lines; i > 0; i--) begin
        line_key[i]  = line_key[i-1];
        line_data[i] = line_data[i-1];
      end
      line_key[0]  = r.key;
      line_data[0] = r.value;
      live_lines++;
    end
    return rep;
  endfunction

  always @(posedge clk) begin : drive_requests
    request_t taken;
    request_t nxt;
    logic     offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken = {in_req_type, in_key, in_value};
        reply_q.push_back(apply_request(taken));
      end
      if (!in_valid || in_ready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          nxt = request_q.pop_front();
          in_req_type <= nxt.req;
          in_key      <= nxt.key;
          in_value    <= nxt.value;
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_valid <= offer;
      end
    end
  end

  always @(posedge clk) begin : pace_replies
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      // hold off long enough for the cache to fill and stall its input
      if (hold_left == 0 && long_holds < 2 && replies_seen >= 300 * (long_holds + 1)
          && request_q.size() > 40) begin
        hold_left = HOLD_CYCLES;
        long_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_pattern_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (rx_mode)
          RX_FREE:   rdy = 1'b1;
          RX_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
          RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
          default:   rdy = ((mode_left % 3) == 0);
        endcase
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      replies_seen++;
      if (reply_q.size() == 0) begin
        $error("unexpected word: hit %0b data %0d", out_hit, out_data);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, out_hit);
          errors++;
        end
        if (out_data !== want.data) begin
          $error("data: expected %0d, got %0d", $signed(want.data), out_data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add(logic req, logic [KEY_W-1:0] key, logic [DATA_W-1:0] value);
    request_t r;
    r.req   = req;
    r.key   = key;
    r.value = value;
    request_q.push_back(r);
  endtask

  // wait until every word has gone through and the cache is quiet
  task automatic drain();
    while (request_q.size() > 0 || in_valid || reply_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    drain();
    @(posedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= cap;
    capacity_reg  = cap;
    cap_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // keys mostly from a small pool sized near the capacity, so hits,
  // refreshes and evictions all happen often
  task automatic random_phase(int n);
    logic [KEY_W-1:0] pool [24];
    int               pool_n;
    int               eff;
    int               i;
    request_t         r;
    eff = (capacity_reg == 0) ? 1 : ((capacity_reg > DEPTH) ? DEPTH : capacity_reg);
    pool_n = eff + $urandom_range(0, 6);
    for (i = 0; i < 24; i++) pool[i] = KEY_W'($urandom_range(0, 65535));
    pool[0] = '0;
    pool[1] = '1;
    for (i = 0; i < n; i++) begin
      r.req = ($urandom_range(0, 1) == 1) ? REQ_SET : REQ_GET;
      if ($urandom_range(0, 7) == 0) r.key = KEY_W'($urandom_range(0, 65535));
      else r.key = pool[$urandom_range(0, pool_n - 1)];
      r.value = $urandom();
      request_q.push_back(r);
    end
  endtask

  initial begin : run
    logic [CAP_W-1:0] caps [8];
    int               p;
    caps = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd9, 5'd17, 5'd2};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty cache, extremes of key and value, refresh of a present key
    add(REQ_GET, 16'h0000, 32'h0000_0000);
    add(REQ_SET, 16'h0000, 32'h8000_0000);
    add(REQ_SET, 16'hFFFF, 32'h7FFF_FFFF);
    add(REQ_SET, 16'h0001, 32'hFFFF_FFFF);
    add(REQ_GET, 16'hFFFF, 32'h0000_0000);
    add(REQ_GET, 16'h0000, 32'hFFFF_FFFF);
    add(REQ_SET, 16'h0000, 32'h1234_5678);
    add(REQ_GET, 16'h0000, 32'h0000_0000);
    add(REQ_GET, 16'h0002, 32'h0000_0000);

    // capacity dropped below the live count: only an insert trims
    set_capacity(5'd2);
    add(REQ_GET, 16'h0001, 32'h0000_0000);
    add(REQ_SET, 16'h0003, 32'h0BAD_F00D);
    add(REQ_GET, 16'hFFFF, 32'h0000_0000);
    add(REQ_GET, 16'h0001, 32'h0000_0000);

    // zero capacity acts as one entry
    set_capacity(5'd0);
    add(REQ_SET, 16'h0007, 32'h0000_0007);
    add(REQ_SET, 16'h0008, 32'h0000_0008);
    add(REQ_GET, 16'h0007, 32'h0000_0000);
    add(REQ_GET, 16'h0008, 32'h0000_0000);

    for (p = 0; p < 8; p++) begin
      set_capacity(caps[p]);
      random_phase(PHASE_WORDS);
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d requests: %0d gets, %0d sets, %0d hits, %0d evictions",
             gets_sent + sets_sent, gets_sent, sets_sent, hits_expected, evictions);
    $display("%0d capacity writes, %0d long receiver hold-offs", cap_writes, long_holds);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
sv/lkv_pkg.sv
sv/lkv_ctrl.sv
sv/lkv_dp.sv
sv/lru_key_value_cache.sv
sim/tb_lru_key_value_cache.sv
